// ===== rtl/core/iol_pkg.sv =====
// Package for the indexed ordered list unit: operation and status codes,
// field widths and the sequencer state type. No dependencies.
package iol_pkg;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 16;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam logic [FUNC_W-1:0] FN_READ       = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_FRONT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_BACK   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INS_AT     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [VAL_W-1:0] NO_VALUE = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_LAST,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/iol_mem.sv =====
// Value store for the indexed ordered list: one write port, one read port
// with registered read data. Uses iol_pkg for the value width.
module iol_mem
    import iol_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [VAL_W-1:0] i_wd,
    input  logic             i_re,
    input  logic [AW-1:0]    i_ra,
    output logic [VAL_W-1:0] o_rd
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== rtl/core/indexed_ordered_list_unit.sv =====
// Indexed ordered list unit: read, insert and delete by position over a
// value store that shifts one element per cycle. Uses iol_pkg and iol_mem.
// An insert moves n = length - position elements and a delete moves
// n = length - position - 1; refused or out-of-range items move none. An
// output stall holds the unit; it takes no new item until the last result is
// registered for output. Reset empties the list and drops results.
module indexed_ordered_list_unit
    import iol_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic        [FUNC_W-1:0]   i_func,
    input  logic        [POS_W-1:0]    i_position,
    input  logic signed [VAL_W-1:0]    i_item_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [VAL_W-1:0]    o_read_value,
    output logic        [STATUS_W-1:0] o_status,
    output logic        [LEN_W-1:0]    o_length
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = CW + POS_W;

    t_state r_state, n_state;

    logic [CW-1:0]       r_len, n_len;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_rd, n_rd;
    logic [AW-1:0]       r_wa, n_wa;
    logic                r_wv, n_wv;
    logic [AW-1:0]       r_pos, n_pos;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]    r_res, n_res;

    logic                r_out_valid, n_out_valid;
    logic [VAL_W-1:0]    r_o_val, n_o_val;
    logic [STATUS_W-1:0] r_o_st, n_o_st;
    logic [LEN_W-1:0]    r_o_len, n_o_len;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [VAL_W-1:0] mem_wd, mem_rd;

    logic                in_acc;
    logic                out_free;
    logic                is_insert;
    logic                is_read_op;
    logic                is_in_ins;
    logic [CMPW-1:0]     pos_ext, len_ext, pe;
    logic                ins_range, del_range, is_full;
    logic [CW+LEN_W-1:0] len_wide;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign is_insert  = (r_func == FN_INS_FRONT) || (r_func == FN_INS_BACK)
                        || (r_func == FN_INS_AT);
    assign is_read_op = (r_func == FN_READ);
    assign is_in_ins  = i_func inside {FN_INS_FRONT, FN_INS_BACK, FN_INS_AT};

    // Effective position of the incoming item.
    assign pos_ext = {{CW{1'b0}}, i_position};
    assign len_ext = {{POS_W{1'b0}}, r_len};
    always_comb begin
        case (i_func)
            FN_INS_FRONT: pe = '0;
            FN_INS_BACK:  pe = len_ext;
            default:      pe = pos_ext;
        endcase
    end

    assign ins_range = pe > len_ext;
    assign del_range = pe >= len_ext;
    assign is_full   = r_len == CW'(CAPACITY);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_in_ins) begin
                        n_state = (ins_range || is_full) ? S_DONE : S_SHIFT;
                    end else if ((i_func == FN_READ) || (i_func == FN_DELETE)) begin
                        n_state = del_range ? S_DONE : S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if ((r_cnt == '0) && !r_wv) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory port and result register.
    always_comb begin
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_rd        = r_rd;
        n_wa        = r_wa;
        n_wv        = 1'b0;
        n_pos       = r_pos;
        n_val       = r_val;
        n_func      = r_func;
        n_status    = r_status;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_o_val     = r_o_val;
        n_o_st      = r_o_st;
        n_o_len     = r_o_len;
        mem_we      = 1'b0;
        mem_wa      = r_wa;
        mem_wd      = mem_rd;
        mem_re      = 1'b0;
        mem_ra      = r_rd[AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func   = i_func;
                    n_val    = i_item_value;
                    n_pos    = pe[AW-1:0];
                    n_res    = NO_VALUE;
                    n_status = ST_DONE;
                    n_cnt    = '0;
                    n_rd     = '0;
                    if (is_in_ins) begin
                        if (ins_range) begin
                            n_status = ST_RANGE;
                        end else if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_cnt = r_len - pe[CW-1:0];
                            n_rd  = r_len - CW'(1);
                        end
                    end else if (i_func == FN_READ) begin
                        if (del_range) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_cnt = CW'(1);
                            n_rd  = pe[CW-1:0];
                        end
                    end else if (i_func == FN_DELETE) begin
                        if (del_range) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_cnt = r_len - pe[CW-1:0] - CW'(1);
                            n_rd  = pe[CW-1:0] + CW'(1);
                        end
                    end else begin
                        n_status = ST_RANGE;
                    end
                end
            end
            S_SHIFT: begin
                // Land the element read last cycle one slot over.
                if (r_wv) begin
                    mem_we = 1'b1;
                    mem_wa = r_wa;
                    mem_wd = mem_rd;
                end
                if (r_cnt != '0) begin
                    mem_re = 1'b1;
                    n_cnt  = r_cnt - CW'(1);
                    n_wv   = !is_read_op;
                    if (is_insert) begin
                        n_rd = r_rd - CW'(1);
                        n_wa = r_rd[AW-1:0] + AW'(1);
                    end else begin
                        n_rd = r_rd + CW'(1);
                        n_wa = r_rd[AW-1:0] - AW'(1);
                    end
                end
            end
            S_LAST: begin
                if (is_insert) begin
                    mem_we = 1'b1;
                    mem_wa = r_pos;
                    mem_wd = r_val;
                    n_len  = r_len + CW'(1);
                end else if (is_read_op) begin
                    n_res = mem_rd;
                end else begin
                    n_len = r_len - CW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_val     = r_res;
                    n_o_st      = r_status;
                    n_o_len     = len_wide[LEN_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign len_wide = {{LEN_W{1'b0}}, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_wv        <= n_wv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd     <= n_rd;
        r_wa     <= n_wa;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_func   <= n_func;
        r_status <= n_status;
        r_res    <= n_res;
        r_o_val  <= n_o_val;
        r_o_st   <= n_o_st;
        r_o_len  <= n_o_len;
    end

    iol_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (mem_re),
        .i_ra  (mem_ra),
        .o_rd  (mem_rd)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_o_val;
    assign o_status     = r_o_st;
    assign o_length     = r_o_len;

endmodule

// ===== tb/sv/tb_indexed_ordered_list_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for indexed_ordered_list_unit: a scoreboard class keeps
// a shadow list and predicts each result; plain tasks drive the valid port and an
// initial block drives the output stall. Depends on iol_pkg and the unit itself.
module tb_indexed_ordered_list_unit;
    import iol_pkg::*;

    localparam int LIST_CAP     = 64;
    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [VAL_W-1:0]    value;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    len;
    } t_list_result;

    // Shadow list plus the queue of results still owed by the unit.
    class t_list_result_board;
        logic [VAL_W-1:0] contents[$];
        t_list_result     owed[$];
        int               errors;

        function int unsigned fill_level();
            return contents.size();
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction

        function logic [STATUS_W-1:0] place(int unsigned pos, logic [VAL_W-1:0] v);
            if (pos > contents.size()) return ST_RANGE;
            if (contents.size() >= LIST_CAP) return ST_FULL;
            contents.insert(pos, v);
            return ST_DONE;
        endfunction

        function void note_item(logic [FUNC_W-1:0] f, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] v);
            t_list_result r;
            r.value = NO_VALUE;
            case (f)
                FN_READ: begin
                    if (pos < contents.size()) begin
                        r.value  = contents[pos];
                        r.status = ST_DONE;
                    end else begin
                        r.status = ST_RANGE;
                    end
                end
                FN_INS_FRONT: r.status = place(0, v);
                FN_INS_BACK:  r.status = place(contents.size(), v);
                FN_INS_AT:    r.status = place(pos, v);
                FN_DELETE: begin
                    if (pos < contents.size()) begin
                        contents.delete(pos);
                        r.status = ST_DONE;
                    end else begin
                        r.status = ST_RANGE;
                    end
                end
                default: r.status = ST_RANGE;
            endcase
            r.len = LEN_W'(contents.size());
            owed.push_back(r);
        endfunction

        function void check_result(logic [VAL_W-1:0] v, logic [STATUS_W-1:0] st,
                                   logic [LEN_W-1:0] len);
            t_list_result e;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none,", $time,
                         " got value %h status %0d length %0d", v, st, len);
                return;
            end
            e = owed.pop_front();
            if (v !== e.value) begin
                errors++;
                $display("%0t: read_value mismatch: expected %h, got %h", $time, e.value, v);
            end
            if (st !== e.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, got %0d", $time, e.status, st);
            end
            if (len !== e.len) begin
                errors++;
                $display("%0t: length mismatch: expected %0d, got %0d", $time, e.len, len);
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic        [FUNC_W-1:0]   op_func = FN_READ;
    logic        [POS_W-1:0]    op_position = '0;
    logic signed [VAL_W-1:0]    op_value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [VAL_W-1:0]    rd_value;
    logic        [STATUS_W-1:0] rd_status;
    logic        [LEN_W-1:0]    rd_length;

    t_list_result_board board = new();
    int  sent;
    bit  calm;
    bit  hold_req;

    indexed_ordered_list_unit #(.CAPACITY(LIST_CAP)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_func       (op_func),
        .i_position   (op_position),
        .i_item_value (op_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_read_value (rd_value),
        .o_status     (rd_status),
        .o_length     (rd_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly valid positions, with the end of the list and wild values now and then.
    function logic [POS_W-1:0] pick_position();
        int unsigned n;
        int r;
        n = board.fill_level();
        r = $urandom_range(0, 9);
        if (r == 0) return POS_W'($urandom);
        if (r == 1 || n == 0) return POS_W'(n);
        return POS_W'($urandom_range(0, n - 1));
    endfunction

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                stall_left = idle_len();
                run_left   = $urandom_range(0, 6);
            end
            out_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            board.check_result(rd_value, rd_status, rd_length);
    end

    // Offer one item and hold it until accepted; keep valid high when gap is zero.
    task automatic send_item(logic [FUNC_W-1:0] f, logic [POS_W-1:0] pos,
                             logic [VAL_W-1:0] v, int gap);
        in_valid    <= 1'b1;
        op_func     <= f;
        op_position <= pos;
        op_value    <= v;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        board.note_item(f, pos, v);
        sent++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic send_mixed();
        int r;
        int unsigned n;
        r = $urandom_range(0, 15);
        n = board.fill_level();
        if (r < 4)
            send_item(FN_READ, pick_position(), $urandom, idle_len());
        else if (r < 6)
            send_item(FN_INS_FRONT, POS_W'($urandom), $urandom, idle_len());
        else if (r < 8)
            send_item(FN_INS_BACK, POS_W'($urandom), $urandom, idle_len());
        else if (r < 11)
            send_item(FN_INS_AT, pick_position(), $urandom, idle_len());
        else if (r < 14)
            send_item(FN_DELETE, pick_position(), $urandom, idle_len());
        else if (r == 14)
            send_item(FUNC_W'($urandom_range(FN_DELETE + 1, (1 << FUNC_W) - 1)),
                      POS_W'($urandom), $urandom, idle_len());
        else
            send_item(FN_INS_AT, POS_W'(n + 1), $urandom, idle_len());
    endtask

    // Fill to capacity, then poke the full list.
    task automatic fill_list();
        int r;
        while (board.fill_level() < LIST_CAP) begin
            r = $urandom_range(0, 2);
            if (r == 0)
                send_item(FN_INS_FRONT, POS_W'($urandom), $urandom, idle_len());
            else if (r == 1)
                send_item(FN_INS_BACK, POS_W'($urandom), $urandom, idle_len());
            else
                send_item(FN_INS_AT, POS_W'($urandom_range(0, board.fill_level())),
                          $urandom, idle_len());
        end
        send_item(FN_INS_FRONT, '0, $urandom, idle_len());
        send_item(FN_INS_BACK, '0, $urandom, idle_len());
        send_item(FN_INS_AT, POS_W'($urandom_range(0, LIST_CAP)), $urandom, idle_len());
        // out-of-range wins over full
        send_item(FN_INS_AT, POS_W'(LIST_CAP + 1), $urandom, idle_len());
        send_item(FN_READ, POS_W'(LIST_CAP - 1), $urandom, idle_len());
        send_item(FN_READ, POS_W'(LIST_CAP), $urandom, idle_len());
    endtask

    task automatic drain_list();
        while (board.fill_level() > 0) begin
            if ($urandom_range(0, 4) == 0)
                send_item(FN_READ, pick_position(), $urandom, idle_len());
            else
                send_item(FN_DELETE, POS_W'($urandom_range(0, board.fill_level() - 1)),
                          $urandom, idle_len());
        end
        send_item(FN_DELETE, POS_W'($urandom_range(0, 3)), $urandom, idle_len());
        send_item(FN_READ, '0, $urandom, idle_len());
    endtask

    initial begin
        int  kind;
        int  limit;
        bit  hold_done;
        bit  pause_done;
        sent       = 0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        board.errors = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list refusals, value extremes, ends of the position range.
        send_item(FN_READ, '0, '0, idle_len());
        send_item(FN_DELETE, '0, '0, idle_len());
        send_item(FN_INS_AT, 16'd1, 32'h0000_0001, idle_len());
        send_item(FN_INS_AT, '0, 32'h8000_0000, idle_len());
        send_item(FN_INS_FRONT, 16'hffff, 32'h7fff_ffff, idle_len());
        send_item(FN_INS_BACK, 16'hffff, 32'hffff_ffff, idle_len());
        send_item(FN_INS_BACK, '0, 32'h0000_0000, idle_len());
        send_item(FN_INS_AT, 16'd2, 32'h1234_5678, idle_len());
        for (int p = 0; p <= 5; p++)
            send_item(FN_READ, POS_W'(p), 32'hdead_beef, idle_len());
        send_item(FN_READ, 16'hffff, '0, idle_len());
        send_item(FN_INS_AT, 16'hffff, 32'h0bad_f00d, idle_len());
        send_item(FN_DELETE, 16'hffff, '0, idle_len());
        send_item(FN_INS_AT, POS_W'(board.fill_level()), 32'h5555_aaaa, idle_len());
        send_item(FN_DELETE, '0, '0, idle_len());
        send_item(FN_DELETE, POS_W'(board.fill_level() - 1), '0, idle_len());
        send_item(FN_DELETE, 16'd1, '0, idle_len());
        for (int f = FN_DELETE + 1; f < (1 << FUNC_W); f++)
            send_item(FUNC_W'(f), 16'hffff, $urandom, idle_len());

        limit = sent + RANDOM_ITEMS;
        while (sent < limit) begin
            calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && sent > 400) begin
                // Back-pressure: keep offering while the receiver holds off.
                hold_done = 1'b1;
                hold_req  = 1'b1;
                for (int k = 0; k < 12; k++)
                    send_item(FN_INS_BACK, POS_W'($urandom), $urandom, 0);
            end
            if (!pause_done && sent > 900) begin
                pause_done = 1'b1;
                settle();
            end
            kind = $urandom_range(0, 11);
            if (kind < 2) begin
                fill_list();
            end else if (kind < 4) begin
                drain_list();
            end else if (kind == 4) begin
                for (int k = 0; k < 10; k++)
                    send_item(FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1)),
                              POS_W'($urandom), $urandom, idle_len());
            end else if (kind == 5) begin
                settle();
            end else begin
                for (int k = 0; k < 20; k++)
                    send_mixed();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
